// ----- hdl/crsf_pkg.sv -----
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, constants and helper functions of the CRSF frame receiver.
// ----------------------------------------------------------------------------
package crsf_pkg;

    // Payload store
    localparam int PAYLOAD_DEPTH = 64;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

    // Frame layout
    localparam int HEADER_BYTES  = 2;
    localparam int MIN_FRAME_LEN = 2;
    localparam int LEN_W         = 6;

    // Channel decode
    localparam int NUM_CHANNELS    = 24;
    localparam int LEGACY_CHANNELS = 16;
    localparam int LEGACY_BITS     = 11;
    localparam int LEGACY_BASE     = 1;
    localparam int SUBSET_BASE     = HEADER_BYTES;
    localparam int SUBSET_BITS_MIN = 10;
    localparam int LEGACY_AVAIL    = LEGACY_CHANNELS * LEGACY_BITS;

    // Datapath widths
    localparam int BUF_W  = 20;   // widest channel plus one byte less one bit
    localparam int CNT_W  = 5;
    localparam int POS_W  = 9;
    localparam int BITS_W = 4;
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 13;
    localparam int RES_W  = 3;
    localparam int ST_W   = 2;
    localparam int OUT_W  = 24;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MAX_LEN     = 3'd0,
        REG_LEGACY_TYPE = 3'd1,
        REG_SUBSET_TYPE = 3'd2,
        REG_CMD_TYPE    = 3'd3,
        REG_ADDR_RX     = 3'd4,
        REG_ADDR_TX     = 3'd5,
        REG_ADDR_SYNC   = 3'd6,
        REG_ADDR_BCAST  = 3'd7
    } cfg_reg_t;

    // Frame status codes
    typedef enum logic [ST_W-1:0] {
        ST_NONE   = 2'd0,
        ST_GOOD   = 2'd1,
        ST_LEGACY = 2'd2
    } frame_status_t;

    localparam logic [RES_W-1:0] RES_LEGACY = 3'd0;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic fetch;    // issue store read
        logic load;     // append read byte to bit buffer
        logic emit;     // write one channel word to output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take a word
        logic decode;       // current input word closes a frame needing decode
        logic load_enough;  // after this load a channel is complete
        logic emit_enough;  // after this emit another channel is complete
        logic last_chan;    // channel in the buffer is the final one
    } dp_stat_t;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [VAL_W-1:0] chan_mask(input logic [BITS_W-1:0] bits);
        logic [VAL_W-1:0] m;
        case (bits)
            4'd10:   m = 13'h03FF;
            4'd11:   m = 13'h07FF;
            4'd12:   m = 13'h0FFF;
            default: m = 13'h1FFF;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/crsf_ram.sv -----
// ----------------------------------------------------------------------------
// crsf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/crsf_dp.sv -----
// ----------------------------------------------------------------------------
// crsf_dp
// Datapath: config registers, frame tracking, CRC, payload store, channel
// bit unpacker and output register.
// ----------------------------------------------------------------------------
module crsf_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [2:0]                  cfg_addr,
    input  logic [7:0]                  cfg_wdata,
    input  logic [7:0]                  rx_byte,
    input  crsf_pkg::ctrl_cmd_t         cmd,
    output crsf_pkg::dp_stat_t          stat,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [crsf_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    // Config
    logic [crsf_pkg::LEN_W-1:0] max_len_reg;
    logic [7:0] legacy_type_reg, subset_type_reg, cmd_type_reg;
    logic [7:0] addr_rx_reg, addr_tx_reg, addr_sync_reg, addr_bcast_reg;

    // Frame tracking
    logic                        in_frame_reg, in_frame_next;
    logic [crsf_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [crsf_pkg::LEN_W-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]                  crc_reg, crc_next;
    logic [7:0]                  type_reg, type_next;
    logic [7:0]                  sub_cfg_reg, sub_cfg_next;
    logic [crsf_pkg::PAYLOAD_DEPTH-1:0] vld_reg, vld_next;
    logic                        vld_q_reg, vld_q_next;

    // Unpacker
    logic [crsf_pkg::BUF_W-1:0]  buf_reg, buf_next;
    logic [crsf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [crsf_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [crsf_pkg::POS_W-1:0]  avail_reg, avail_next;
    logic [crsf_pkg::BITS_W-1:0] bits_reg, bits_next;
    logic [crsf_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [crsf_pkg::ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [crsf_pkg::ST_W-1:0]   dec_st_reg, dec_st_next;
    logic [crsf_pkg::RES_W-1:0]  dec_res_reg, dec_res_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [crsf_pkg::ST_W-1:0]   out_st_reg, out_st_next;
    logic                        out_chv_reg, out_chv_next;
    logic [crsf_pkg::IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [crsf_pkg::VAL_W-1:0]  out_val_reg, out_val_next;
    logic [crsf_pkg::RES_W-1:0]  out_res_reg, out_res_next;
    logic                        out_last_reg, out_last_next;

    // Combinational
    logic                        addr_hit, len_bad, frame_end, crc_ok;
    logic                        is_legacy, is_subset, is_cmd, sub_none, store_wr;
    logic [crsf_pkg::LEN_W-1:0]  cnt_inc;
    logic [crsf_pkg::POS_W-1:0]  sub_avail;
    logic [crsf_pkg::BITS_W-1:0] sub_bits;
    logic [crsf_pkg::IDX_W-1:0]  sub_start;
    logic [crsf_pkg::ST_W-1:0]   end_st;
    logic [7:0]                  ram_q, rd_byte;

    // Frame checks on the incoming word
    assign addr_hit = (rx_byte == addr_rx_reg) || (rx_byte == addr_tx_reg) ||
                      (rx_byte == addr_sync_reg) || (rx_byte == addr_bcast_reg);
    assign len_bad  = (rx_byte < 8'(crsf_pkg::MIN_FRAME_LEN)) ||
                      (rx_byte > {2'b00, max_len_reg});
    assign cnt_inc  = byte_cnt_reg + 1'b1;
    assign frame_end = in_frame_reg && (len_reg != '0) && (cnt_inc >= len_reg);
    assign crc_ok    = (crc_reg == rx_byte);

    assign is_legacy = (type_reg == legacy_type_reg);
    assign is_subset = (type_reg == subset_type_reg);
    assign is_cmd    = (type_reg == cmd_type_reg);

    // Subset frame: bits of channel data after type and config byte
    assign sub_avail = (len_reg >= crsf_pkg::LEN_W'(crsf_pkg::HEADER_BYTES + 1)) ?
                       {len_reg - crsf_pkg::LEN_W'(crsf_pkg::HEADER_BYTES + 1), 3'b000} :
                       '0;
    assign sub_bits  = crsf_pkg::BITS_W'(crsf_pkg::SUBSET_BITS_MIN) + {2'b00, sub_cfg_reg[6:5]};
    assign sub_start = sub_cfg_reg[4:0];
    assign sub_none  = (sub_avail < {5'b0, sub_bits}) ||
                       ({1'b0, sub_start} >= 6'(crsf_pkg::NUM_CHANNELS));

    assign stat.decode = frame_end && crc_ok && (is_legacy || (is_subset && !sub_none));

    always_comb
    begin
        end_st = crsf_pkg::ST_NONE;
        if (frame_end && crc_ok && !is_legacy && (is_subset || is_cmd))
        begin
            end_st = crsf_pkg::ST_GOOD;
        end
    end

    assign store_wr = cmd.accept && in_frame_reg && (len_reg != '0) && !frame_end;

    crsf_ram #(
        .WIDTH (8),
        .DEPTH (crsf_pkg::PAYLOAD_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_wr),
        .waddr (crsf_pkg::ADDR_W'(byte_cnt_reg)),
        .wdata (rx_byte),
        .re    (cmd.fetch),
        .raddr (rd_addr_reg),
        .rdata (ram_q)
    );

    // Entries never written since reset read as zero
    assign rd_byte = ram_q & {8{vld_q_reg}};

    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.load_enough = ({1'b0, cnt_reg} + 6'd8) >= {2'b00, bits_reg};
    assign stat.emit_enough = {1'b0, cnt_reg} >= {1'b0, bits_reg, 1'b0};
    assign stat.last_chan   = (({1'b0, pos_reg} + {5'b0, bits_reg, 1'b0}) > {1'b0, avail_reg}) ||
                              (({1'b0, idx_reg} + 6'd1) >= 6'(crsf_pkg::NUM_CHANNELS));

    always_comb
    begin
        in_frame_next = in_frame_reg;
        len_next      = len_reg;
        byte_cnt_next = byte_cnt_reg;
        crc_next      = crc_reg;
        type_next     = type_reg;
        sub_cfg_next  = sub_cfg_reg;
        vld_next      = vld_reg;
        vld_q_next    = vld_q_reg;
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        avail_next    = avail_reg;
        bits_next     = bits_reg;
        idx_next      = idx_reg;
        rd_addr_next  = rd_addr_reg;
        dec_st_next   = dec_st_reg;
        dec_res_next  = dec_res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_st_next   = out_st_reg;
        out_chv_next  = out_chv_reg;
        out_idx_next  = out_idx_reg;
        out_val_next  = out_val_reg;
        out_res_next  = out_res_reg;
        out_last_next = out_last_reg;

        if (cmd.accept)
        begin
            if (!in_frame_reg)
            begin
                if (addr_hit)
                begin
                    in_frame_next = 1'b1;
                    len_next      = '0;
                end
            end
            else if (len_reg == '0)
            begin
                crc_next      = '0;
                byte_cnt_next = '0;
                if (len_bad)
                begin
                    in_frame_next = 1'b0;
                    len_next      = '0;
                end
                else
                begin
                    len_next = rx_byte[crsf_pkg::LEN_W-1:0];
                end
            end
            else if (frame_end)
            begin
                in_frame_next = 1'b0;
                len_next      = '0;
                byte_cnt_next = cnt_inc;
                if (stat.decode)
                begin
                    buf_next     = '0;
                    cnt_next     = '0;
                    pos_next     = '0;
                    if (is_legacy)
                    begin
                        avail_next   = crsf_pkg::POS_W'(crsf_pkg::LEGACY_AVAIL);
                        bits_next    = crsf_pkg::BITS_W'(crsf_pkg::LEGACY_BITS);
                        idx_next     = '0;
                        rd_addr_next = crsf_pkg::ADDR_W'(crsf_pkg::LEGACY_BASE);
                        dec_st_next  = crsf_pkg::ST_LEGACY;
                        dec_res_next = crsf_pkg::RES_LEGACY;
                    end
                    else
                    begin
                        avail_next   = sub_avail;
                        bits_next    = sub_bits;
                        idx_next     = sub_start;
                        rd_addr_next = crsf_pkg::ADDR_W'(crsf_pkg::SUBSET_BASE);
                        dec_st_next  = crsf_pkg::ST_GOOD;
                        dec_res_next = {1'b0, sub_cfg_reg[6:5]} + 3'd1;
                    end
                end
            end
            else
            begin
                byte_cnt_next = cnt_inc;
                crc_next      = crsf_pkg::crc8_next(crc_reg, rx_byte);
                vld_next[crsf_pkg::ADDR_W'(byte_cnt_reg)] = 1'b1;
                if (byte_cnt_reg == '0)
                begin
                    type_next = rx_byte;
                end
                if (byte_cnt_reg == crsf_pkg::LEN_W'(1))
                begin
                    sub_cfg_next = rx_byte;
                end
            end

            // Every word that needs no channel decode yields one status word
            if (!stat.decode)
            begin
                out_valid_next = 1'b1;
                out_st_next    = end_st;
                out_chv_next   = 1'b0;
                out_idx_next   = '0;
                out_val_next   = '0;
                out_res_next   = '0;
                out_last_next  = 1'b1;
            end
        end

        if (cmd.fetch)
        begin
            vld_q_next = vld_reg[rd_addr_reg];
        end

        if (cmd.load)
        begin
            buf_next     = buf_reg | (crsf_pkg::BUF_W'(rd_byte) << cnt_reg);
            cnt_next     = cnt_reg + crsf_pkg::CNT_W'(8);
            rd_addr_next = rd_addr_reg + 1'b1;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_st_next    = dec_st_reg;
            out_chv_next   = 1'b1;
            out_idx_next   = idx_reg;
            out_val_next   = buf_reg[crsf_pkg::VAL_W-1:0] & crsf_pkg::chan_mask(bits_reg);
            out_res_next   = dec_res_reg;
            out_last_next  = stat.last_chan;
            buf_next       = buf_reg >> bits_reg;
            cnt_next       = cnt_reg - {1'b0, bits_reg};
            pos_next       = pos_reg + {5'b0, bits_reg};
            idx_next       = idx_reg + 1'b1;
        end
    end

    // Config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg     <= 6'd62;
            legacy_type_reg <= 8'd22;
            subset_type_reg <= 8'd23;
            cmd_type_reg    <= 8'd50;
            addr_rx_reg     <= 8'd236;
            addr_tx_reg     <= 8'd238;
            addr_sync_reg   <= 8'd200;
            addr_bcast_reg  <= 8'd0;
        end
        else if (cfg_wen)
        begin
            case (crsf_pkg::cfg_reg_t'(cfg_addr))
                crsf_pkg::REG_MAX_LEN:     max_len_reg     <= cfg_wdata[crsf_pkg::LEN_W-1:0];
                crsf_pkg::REG_LEGACY_TYPE: legacy_type_reg <= cfg_wdata;
                crsf_pkg::REG_SUBSET_TYPE: subset_type_reg <= cfg_wdata;
                crsf_pkg::REG_CMD_TYPE:    cmd_type_reg    <= cfg_wdata;
                crsf_pkg::REG_ADDR_RX:     addr_rx_reg     <= cfg_wdata;
                crsf_pkg::REG_ADDR_TX:     addr_tx_reg     <= cfg_wdata;
                crsf_pkg::REG_ADDR_SYNC:   addr_sync_reg   <= cfg_wdata;
                crsf_pkg::REG_ADDR_BCAST:  addr_bcast_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            len_reg       <= '0;
            byte_cnt_reg  <= '0;
            crc_reg       <= '0;
            type_reg      <= '0;
            sub_cfg_reg   <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            len_reg       <= len_next;
            byte_cnt_reg  <= byte_cnt_next;
            crc_reg       <= crc_next;
            type_reg      <= type_next;
            sub_cfg_reg   <= sub_cfg_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vld_q_reg    <= vld_q_next;
        buf_reg      <= buf_next;
        cnt_reg      <= cnt_next;
        pos_reg      <= pos_next;
        avail_reg    <= avail_next;
        bits_reg     <= bits_next;
        idx_reg      <= idx_next;
        rd_addr_reg  <= rd_addr_next;
        dec_st_reg   <= dec_st_next;
        dec_res_reg  <= dec_res_next;
        out_st_reg   <= out_st_next;
        out_chv_reg  <= out_chv_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg, out_val_reg, out_idx_reg, out_st_reg};
    assign m_tuser  = out_chv_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/crsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// crsf_ctrl
// Sequencer: takes input words, then walks the channel unpacker through
// fetch, load and emit steps after a good RC frame.
// ----------------------------------------------------------------------------
module crsf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  crsf_pkg::dp_stat_t  stat,
    output crsf_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_LOAD  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = s_tvalid && s_tready;
                if (cmd.accept && stat.decode)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = stat.load_enough ? S_EMIT : S_FETCH;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_chan)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.emit_enough)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/crsf_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// CRSF frame receiver: finds frames in a byte stream, checks length and
// CRC-8 (poly 0xD5) and unpacks RC channels of good legacy and subset frames.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Contents
//  s_*       in   tvalid/tready      tdata[7:0] rx_byte
//  m_*       out  tvalid/tready      tdata status/index/value/res, tuser
//                                    channel_valid, tlast last_result
//  cfg_*     in   cfg_wen strobe     cfg_addr register index, cfg_wdata value
//
//  One input word per cycle while no decode runs and the output register
//  is free; its status word sits in the output register the cycle after.
//  A good RC frame runs the unpacker: a fetch and a load step per store
//  byte read (one registered RAM read port) plus an emit step per channel,
//  sixteen channels for a legacy frame; s_tready is low meanwhile.
//  Output stalls hold the output register and stop input and unpacking.
//  Reset clears frame state and the per-entry valid bits of the payload
//  store at once; no clearing pass.
//
module crsf_frame_receiver (
    input  logic                       clk,
    input  logic                       rst_n,
    // input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
    // result words
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [crsf_pkg::OUT_W-1:0] m_tdata,   // [1:0] frame_status, [6:2] channel_index,
                                                  // [19:7] channel_value, [22:20] resolution,
                                                  // [23] zero
    output logic                       m_tuser,   // [0] channel_valid
    output logic                       m_tlast,   // last_result
    // configuration writes
    input  logic                       cfg_wen,
    input  logic [2:0]                 cfg_addr,
    input  logic [7:0]                 cfg_wdata
);

    crsf_pkg::ctrl_cmd_t cmd;
    crsf_pkg::dp_stat_t  stat;

    // Sequencer
    crsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Frame checks, payload store, unpacker and output register
    crsf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crsf_frame_receiver. A byte-level model of the
// frame parser predicts every result word; directed frames, a long output
// hold-off and randomised frame traffic run under several register settings.
// ----------------------------------------------------------------------------
module tb;

    import crsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 80;    // room for a legacy unpack to finish
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off

    // one predicted result word
    typedef struct packed {
        frame_status_t      status;
        logic               has_chan;
        logic [IDX_W-1:0]   chan;
        logic [VAL_W-1:0]   value;
        logic [RES_W-1:0]   res;
        logic               last;
    } result_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;    // [1:0] status, [6:2] index, [19:7] value,
                                      // [22:20] resolution, [23] zero
    logic                 m_tuser;    // [0] channel_valid
    logic                 m_tlast;
    logic                 cfg_wen;
    logic [2:0]           cfg_addr;
    logic [7:0]           cfg_wdata;

    // model copy of the registers, reset values
    logic [7:0] reg_val [8] = '{8'd62, 8'd22, 8'd23, 8'd50,
                                8'd236, 8'd238, 8'd200, 8'd0};

    // model copy of the frame state
    logic       fr_open  = 1'b0;
    logic [7:0] fr_len   = 8'd0;
    logic [6:0] fr_count = 7'd0;
    logic [7:0] fr_crc   = 8'd0;
    logic [7:0] payload_mem [PAYLOAD_DEPTH] = '{default: 8'd0};

    result_word_t pending_words[$];   // predicted words not yet seen
    logic [7:0]   body_buf [PAYLOAD_DEPTH];  // frame bytes after the type byte
    int           errors     = 0;
    int           bytes_sent = 0;
    int           sink_hold  = 0;     // hold-off request, counted down by the sink
    logic         no_gaps    = 1'b0;  // both sides run flat out while set

    crsf_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------

    // CRC-8, poly 0xD5, MSB first
    function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8)
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    // LSB-first bit field out of the payload store; entries past the end read 0
    function automatic logic [VAL_W-1:0] store_bits(input int base, input int pos,
                                                    input int nbits);
        logic [VAL_W-1:0] v;
        int               b;
        int               ent;
        v = '0;
        for (int i = 0; i < nbits; i++)
        begin
            b   = pos + i;
            ent = base + b / 8;
            if (ent < PAYLOAD_DEPTH && payload_mem[ent][b % 8])
                v[i] = 1'b1;
        end
        return v;
    endfunction

    task automatic push_word(input frame_status_t st, input logic has, input int chan,
                             input logic [VAL_W-1:0] value, input logic [RES_W-1:0] res);
        result_word_t w;
        w.status   = st;
        w.has_chan = has;
        w.chan     = IDX_W'(chan);
        w.value    = value;
        w.res      = res;
        w.last     = 1'b0;
        pending_words.push_back(w);
    endtask

    // Predict the result words of one accepted input byte.
    task automatic model_rx_byte(input logic [7:0] b);
        frame_status_t fin;
        result_word_t  w;
        logic [7:0]    kind;
        logic [7:0]    sub_cfg;
        int            added;
        int            nbits;
        int            count;
        int            len_i;
        fin   = ST_NONE;
        added = 0;
        if (!fr_open)
        begin
            // hunting for an address byte; everything else is dropped
            if (b == reg_val[REG_ADDR_RX] || b == reg_val[REG_ADDR_TX] ||
                b == reg_val[REG_ADDR_SYNC] || b == reg_val[REG_ADDR_BCAST])
            begin
                fr_open = 1'b1;
                fr_len  = 8'd0;
            end
        end
        else if (fr_len == 8'd0)
        begin
            // length byte
            fr_crc   = 8'd0;
            fr_count = 7'd0;
            fr_len   = b;
            if (b < MIN_FRAME_LEN || b > reg_val[REG_MAX_LEN])
            begin
                fr_open = 1'b0;
                fr_len  = 8'd0;
            end
        end
        else
        begin
            fr_count = fr_count + 7'd1;
            if (fr_count >= fr_len)
            begin
                // CRC byte closes the frame
                if (fr_crc == b)
                begin
                    kind = payload_mem[0];
                    if (kind == reg_val[REG_LEGACY_TYPE])
                    begin
                        // legacy wins when type codes coincide; store read whatever its age
                        for (int ch = 0; ch < LEGACY_CHANNELS; ch++)
                        begin
                            push_word(ST_LEGACY, 1'b1, ch,
                                      store_bits(LEGACY_BASE, ch * LEGACY_BITS, LEGACY_BITS),
                                      RES_LEGACY);
                            added++;
                        end
                        fin = ST_LEGACY;
                    end
                    else if (kind == reg_val[REG_SUBSET_TYPE])
                    begin
                        sub_cfg = payload_mem[1];
                        nbits   = SUBSET_BITS_MIN + sub_cfg[6:5];
                        len_i   = fr_len;
                        count   = (len_i >= HEADER_BYTES + 1) ?
                                  ((len_i - HEADER_BYTES - 1) * 8) / nbits : 0;
                        // channels past the top index are dropped
                        for (int c = 0; c < count && sub_cfg[4:0] + c < NUM_CHANNELS; c++)
                        begin
                            push_word(ST_GOOD, 1'b1, sub_cfg[4:0] + c,
                                      store_bits(SUBSET_BASE, c * nbits, nbits),
                                      RES_W'(sub_cfg[6:5] + 1));
                            added++;
                        end
                        fin = ST_GOOD;
                    end
                    else if (kind == reg_val[REG_CMD_TYPE])
                        fin = ST_GOOD;
                end
                fr_open = 1'b0;
                fr_len  = 8'd0;
            end
            else
            begin
                payload_mem[fr_count - 7'd1] = b;
                fr_crc = crc8_d5(fr_crc, b);
            end
        end
        if (added == 0)
            push_word(fin, 1'b0, 0, '0, '0);
        w      = pending_words.pop_back();
        w.last = 1'b1;
        pending_words.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_addr();
        return reg_val[REG_ADDR_RX + $urandom_range(0, 3)];
    endfunction

    // Offer one input word, wait for the handshake, then predict its results.
    // Valid stays high between back-to-back words.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        bytes_sent++;
        model_rx_byte(b);
    endtask

    task automatic fill_body(input int n);
        for (int i = 0; i < n; i++)
            body_buf[i] = 8'($urandom_range(0, 255));
    endtask

    // address, length, type, body_buf[0..nbody-1], CRC
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] kind,
                              input int nbody, input logic bad_crc);
        logic [7:0] crc;
        crc = crc8_d5(8'h00, kind);
        for (int i = 0; i < nbody; i++)
            crc = crc8_d5(crc, body_buf[i]);
        if (bad_crc)
            crc = crc ^ 8'($urandom_range(1, 255));
        push_byte(addr);
        push_byte(8'(nbody + HEADER_BYTES));
        push_byte(kind);
        for (int i = 0; i < nbody; i++)
            push_byte(body_buf[i]);
        push_byte(crc);
    endtask

    // Drop valid and wait until every predicted word is out, plus unpack time.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        reg_val[r] = (r == REG_MAX_LEN) ? 8'(v[LEN_W-1:0]) : v;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Mostly good frames with random content; the rest broken frames and noise.
    task automatic random_frames(input int n_bytes);
        int         stop;
        int         r;
        int         maxb;
        int         nb;
        logic [7:0] kind;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop)
        begin
            no_gaps = ($urandom_range(0, 6) == 0);
            maxb    = reg_val[REG_MAX_LEN] - HEADER_BYTES;
            r       = $urandom_range(0, 99);
            if (r < 25)
            begin
                // legacy, usually full length, sometimes short
                nb = (maxb >= 22 && $urandom_range(0, 4) != 0) ? 22 : $urandom_range(0, maxb);
                fill_body(nb);
                send_frame(pick_addr(), reg_val[REG_LEGACY_TYPE], nb, 1'b0);
            end
            else if (r < 50)
            begin
                // subset, mostly small
                nb = ($urandom_range(0, 7) == 0) ? maxb
                                                 : $urandom_range(0, (maxb < 12) ? maxb : 12);
                fill_body(nb);
                send_frame(pick_addr(), reg_val[REG_SUBSET_TYPE], nb, 1'b0);
            end
            else if (r < 60)
            begin
                nb = $urandom_range(0, (maxb < 6) ? maxb : 6);
                fill_body(nb);
                send_frame(pick_addr(), reg_val[REG_CMD_TYPE], nb, 1'b0);
            end
            else if (r < 68)
            begin
                // any type code, good CRC
                nb = $urandom_range(0, (maxb < 6) ? maxb : 6);
                fill_body(nb);
                send_frame(pick_addr(), 8'($urandom_range(0, 255)), nb, 1'b0);
            end
            else if (r < 78)
            begin
                case ($urandom_range(0, 3))
                    0:       kind = reg_val[REG_LEGACY_TYPE];
                    1:       kind = reg_val[REG_SUBSET_TYPE];
                    2:       kind = reg_val[REG_CMD_TYPE];
                    default: kind = 8'($urandom_range(0, 255));
                endcase
                nb = $urandom_range(0, (maxb < 22) ? maxb : 22);
                fill_body(nb);
                send_frame(pick_addr(), kind, nb, 1'b1);
            end
            else if (r < 86)
            begin
                // length out of range
                push_byte(pick_addr());
                if ($urandom_range(0, 1) == 0)
                    push_byte(8'($urandom_range(0, MIN_FRAME_LEN - 1)));
                else
                    push_byte(8'($urandom_range(reg_val[REG_MAX_LEN] + 1, 255)));
            end
            else
            begin
                // raw noise, then run out whatever frame it opened
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)));
                while (fr_open)
                    push_byte((fr_len == 8'd0) ? 8'd0 : 8'($urandom_range(0, 255)));
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: one case of each kind.
    task automatic test_directed_cases();
        push_byte(8'hFF);                       // not an address: dropped
        push_byte(reg_val[REG_ADDR_RX]);
        push_byte(8'd1);                        // length below minimum
        push_byte(reg_val[REG_ADDR_BCAST]);
        push_byte(8'hFF);                       // length above maximum
        send_frame(reg_val[REG_ADDR_TX], reg_val[REG_SUBSET_TYPE], 0, 1'b0);  // no channel bytes
        send_frame(reg_val[REG_ADDR_SYNC], reg_val[REG_LEGACY_TYPE], 0, 1'b0); // short legacy
        send_frame(reg_val[REG_ADDR_RX], reg_val[REG_CMD_TYPE], 0, 1'b1);     // bad CRC
        send_frame(reg_val[REG_ADDR_BCAST], reg_val[REG_CMD_TYPE], 0, 1'b0);
        // subset starting beyond the last channel: one status word only
        body_buf[0] = 8'h7E;
        body_buf[1] = 8'hAA;
        body_buf[2] = 8'h55;
        send_frame(reg_val[REG_ADDR_RX], reg_val[REG_SUBSET_TYPE], 3, 1'b0);
        send_frame(reg_val[REG_ADDR_TX], 8'h00, 0, 1'b0);                     // unknown type
        settle();
    endtask

    // Receiver holds off while full frames keep coming: input must stall.
    task automatic test_output_hold_off();
        no_gaps   = 1'b1;
        sink_hold = HOLD_CYCLES;
        fill_body(22);
        send_frame(reg_val[REG_ADDR_SYNC], reg_val[REG_LEGACY_TYPE], 22, 1'b0);
        // 13-bit subset from channel 0, long enough for all 24 channels
        fill_body(40);
        body_buf[0] = 8'h60;
        send_frame(reg_val[REG_ADDR_TX], reg_val[REG_SUBSET_TYPE], 40, 1'b0);
        no_gaps = 1'b0;
        settle();
    endtask

    task automatic test_random_reset_config();
        random_frames(25);
        settle();
    endtask

    // Shortest length limit, all type codes equal, extreme addresses.
    task automatic test_extreme_config();
        write_reg(REG_MAX_LEN, 8'd2);
        write_reg(REG_LEGACY_TYPE, 8'hFF);
        write_reg(REG_SUBSET_TYPE, 8'hFF);
        write_reg(REG_CMD_TYPE, 8'hFF);
        write_reg(REG_ADDR_RX, 8'h00);
        write_reg(REG_ADDR_TX, 8'hFF);
        write_reg(REG_ADDR_SYNC, 8'hFF);
        write_reg(REG_ADDR_BCAST, 8'h00);
        // legacy takes precedence, channels come from older frames' bytes
        send_frame(8'hFF, 8'hFF, 0, 1'b0);
        push_byte(8'h00);
        push_byte(8'd3);                        // one above the limit
        random_frames(10);
        settle();
    endtask

    // Random limit and codes; subset and command share a code.
    task automatic test_mixed_config();
        logic [7:0] sub_code;
        sub_code = 8'($urandom_range(0, 255));
        write_reg(REG_MAX_LEN, 8'($urandom_range(8, 61)));
        write_reg(REG_LEGACY_TYPE, 8'($urandom_range(0, 255)));
        write_reg(REG_SUBSET_TYPE, sub_code);
        write_reg(REG_CMD_TYPE, sub_code);
        write_reg(REG_ADDR_RX, 8'($urandom_range(0, 255)));
        write_reg(REG_ADDR_TX, 8'($urandom_range(0, 255)));
        write_reg(REG_ADDR_SYNC, 8'($urandom_range(0, 255)));
        write_reg(REG_ADDR_BCAST, 8'($urandom_range(0, 255)));
        random_frames(25);
        settle();
    endtask

    // Back to reset codes, including the reset length limit of 62.
    task automatic test_longest_frames();
        write_reg(REG_MAX_LEN, 8'd62);
        write_reg(REG_LEGACY_TYPE, 8'd22);
        write_reg(REG_SUBSET_TYPE, 8'd23);
        write_reg(REG_CMD_TYPE, 8'd50);
        write_reg(REG_ADDR_RX, 8'd236);
        write_reg(REG_ADDR_TX, 8'd238);
        write_reg(REG_ADDR_SYNC, 8'd200);
        write_reg(REG_ADDR_BCAST, 8'd0);
        // length 62, 10-bit from channel 0: more channels than the top index
        fill_body(60);
        body_buf[0] = 8'h00;
        send_frame(reg_val[REG_ADDR_RX], reg_val[REG_SUBSET_TYPE], 60, 1'b0);
        fill_body(60);
        send_frame(reg_val[REG_ADDR_SYNC], reg_val[REG_CMD_TYPE], 60, 1'b0);
        random_frames(10);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // random stalls; a hold-off request overrides them
    initial
    begin : result_sink
        int   stall_left;
        logic rdy;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
            m_tready <= rdy;
        end
    end

    // each accepted result word against the oldest prediction
    always @(posedge clk)
    begin : word_check
        result_word_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_words.size() == 0)
                report_error($sformatf("unexpected word %h user %b last %b",
                                       m_tdata, m_tuser, m_tlast));
            else
            begin
                want = pending_words.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_error($sformatf("frame_status %0d, want %0d",
                                           m_tdata[1:0], want.status));
                if (m_tuser !== want.has_chan)
                    report_error($sformatf("channel_valid %b, want %b", m_tuser, want.has_chan));
                if (m_tdata[6:2] !== want.chan)
                    report_error($sformatf("channel_index %0d, want %0d",
                                           m_tdata[6:2], want.chan));
                if (m_tdata[19:7] !== want.value)
                    report_error($sformatf("channel_value %h, want %h (index %0d)",
                                           m_tdata[19:7], want.value, want.chan));
                if (m_tdata[22:20] !== want.res)
                    report_error($sformatf("resolution %0d, want %0d",
                                           m_tdata[22:20], want.res));
                if (m_tdata[OUT_W-1] !== 1'b0)
                    report_error("tdata pad bit set");
                if (m_tlast !== want.last)
                    report_error($sformatf("last_result %b, want %b", m_tlast, want.last));
            end
        end
    end

    // ends a hung run: no word moving on either side for too long
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        cfg_wen   = 1'b0;
        cfg_addr  = REG_MAX_LEN;
        cfg_wdata = 8'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_output_hold_off();
        test_random_reset_config();
        test_extreme_config();
        test_mixed_config();
        test_longest_frames();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- crsf_frame_receiver.f -----
hdl/crsf_pkg.sv
hdl/crsf_ram.sv
hdl/crsf_dp.sv
hdl/crsf_ctrl.sv
hdl/crsf_frame_receiver.sv
sim/tb.sv
